[design/svpd_pkg.sv]
// ----------------------------------------------------------------------------
// svpd_pkg: shared types and constants for the strided view permute detector
// Command codes from controller to datapath, status bundle back.
// ----------------------------------------------------------------------------
package svpd_pkg;

    // Width of one multiplier operand slice; the product unit takes one slice a cycle.
    localparam int CHUNK_W    = 16;
    // Base list counters wrap at this width.
    localparam int BASE_CNT_W = 4;
    // Width of the permutation entry on the result channel.
    localparam int PERM_W     = 3;
    // Width of the element count products and the running stride.
    localparam int PROD_W     = 64;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_ACCEPT,
        CMD_MUL_STEP,
        CMD_EVAL_INIT,
        CMD_RD_I,
        CMD_LOAD_PIVOT,
        CMD_COMPARE,
        CMD_WRITE_PIVOT,
        CMD_RD_DENSE,
        CMD_DENSE_CHECK,
        CMD_DENSE_MUL,
        CMD_RD_OUT,
        CMD_EMIT,
        CMD_REJECT
    } svpd_cmd_t;

    typedef struct packed {
        logic in_need_mul;
        logic in_last;
        logic mul_last;
        logic pre_reject;
        logic single;
        logic j_last;
        logic sort_more;
        logic dense_bad;
        logic d_zero;
        logic base_mismatch;
        logic k_last;
        logic out_free;
    } svpd_status_t;

endpackage

[design/svpd_in_if.sv]
// ----------------------------------------------------------------------------
// svpd_in_if: descriptor item channel
// One transaction carries one view or base dimension item.
// ----------------------------------------------------------------------------
interface svpd_in_if #(
    parameter int SIZE_BITS   = 32,
    parameter int STRIDE_BITS = 48
);
    logic                   valid;
    logic                   ready;
    logic                   mode;
    logic [SIZE_BITS-1:0]   dim_size;
    logic [STRIDE_BITS-1:0] dim_stride;
    logic                   size_present;
    logic                   stride_present;
    logic                   last;

    modport source (
        output valid, mode, dim_size, dim_stride, size_present, stride_present, last,
        input  ready
    );

    modport sink (
        input  valid, mode, dim_size, dim_stride, size_present, stride_present, last,
        output ready
    );
endinterface

[design/svpd_out_if.sv]
// ----------------------------------------------------------------------------
// svpd_out_if: result channel
// One transaction carries one permutation entry or the reject result.
// ----------------------------------------------------------------------------
interface svpd_out_if #(
    parameter int SIZE_BITS = 32
);
    logic                 valid;
    logic                 ready;
    logic                 accepted;
    logic [2:0]           perm_entry;
    logic [SIZE_BITS-1:0] sorted_size;
    logic                 last_out;

    modport source (
        output valid, accepted, perm_entry, sorted_size, last_out,
        input  ready
    );

    modport sink (
        input  valid, accepted, perm_entry, sorted_size, last_out,
        output ready
    );
endinterface

[design/svpd_ram.sv]
// ----------------------------------------------------------------------------
// svpd_ram: generic single write, single read RAM
// Registered read data, updated only when rd_en is high.
// ----------------------------------------------------------------------------
module svpd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[design/svpd_datapath.sv]
// ----------------------------------------------------------------------------
// svpd_datapath: descriptor store, sort, density check and result register
// Executes one controller command per cycle and reports status.
// ----------------------------------------------------------------------------
module svpd_datapath #(
    parameter int MAX_DIMS    = 8,
    parameter int SIZE_BITS   = 32,
    parameter int STRIDE_BITS = 48
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  svpd_pkg::svpd_cmd_t          cmd,
    output svpd_pkg::svpd_status_t       status,
    // descriptor payload
    input  logic                         mode,
    input  logic [SIZE_BITS-1:0]         dim_size,
    input  logic [STRIDE_BITS-1:0]       dim_stride,
    input  logic                         size_present,
    input  logic                         stride_present,
    input  logic                         last,
    // result channel
    input  logic                         result_ready,
    output logic                         result_valid,
    output logic                         accepted,
    output logic [svpd_pkg::PERM_W-1:0]  perm_entry,
    output logic [SIZE_BITS-1:0]         sorted_size,
    output logic                         last_out
);

    localparam int IDX_W  = $clog2(MAX_DIMS);
    localparam int CNT_W  = $clog2(MAX_DIMS + 1);
    localparam int NCHUNK = (SIZE_BITS + svpd_pkg::CHUNK_W - 1) / svpd_pkg::CHUNK_W;
    localparam int OP_W   = NCHUNK * svpd_pkg::CHUNK_W;
    localparam int REC_W  = STRIDE_BITS + SIZE_BITS + IDX_W;
    localparam int PW     = svpd_pkg::PROD_W;
    localparam int BW     = svpd_pkg::BASE_CNT_W;

    typedef enum logic [1:0] {
        MT_VIEW,
        MT_BASE,
        MT_RUN
    } mul_target_t;

    // record layout {stride, size, axis index}
    logic                    we;
    logic [IDX_W-1:0]        waddr;
    logic [REC_W-1:0]        wdata;
    logic                    re;
    logic [IDX_W-1:0]        raddr;
    logic [REC_W-1:0]        rdata;

    logic [IDX_W-1:0]        rd_idx;
    logic [SIZE_BITS-1:0]    rd_size;
    logic [STRIDE_BITS-1:0]  rd_stride;
    logic [SIZE_BITS-1:0]    piv_size;
    logic [STRIDE_BITS-1:0]  piv_stride;

    logic [CNT_W-1:0]        view_count_reg, view_count_next;
    logic [BW-1:0]           base_size_count_reg, base_size_count_next;
    logic [BW-1:0]           base_stride_count_reg, base_stride_count_next;
    logic [PW-1:0]           view_product_reg, view_product_next;
    logic [PW-1:0]           base_product_reg, base_product_next;
    logic [PW-1:0]           running_reg, running_next;
    logic                    overflow_reg, overflow_next;
    logic [IDX_W-1:0]        i_reg, i_next;
    logic [IDX_W-1:0]        j_reg, j_next;
    logic [IDX_W-1:0]        d_reg, d_next;
    logic [IDX_W-1:0]        k_reg, k_next;
    logic                    out_valid_reg, out_valid_next;

    logic [REC_W-1:0]        pivot_reg, pivot_next;
    logic [PW-1:0]           mcand_reg, mcand_next;
    logic [OP_W-1:0]         op_reg, op_next;
    logic [PW-1:0]           psum_reg, psum_next;
    mul_target_t             msel_reg, msel_next;
    logic [IDX_W-1:0]        perm_reg [MAX_DIMS];
    logic [IDX_W-1:0]        perm_next [MAX_DIMS];
    logic                    out_accepted_reg, out_accepted_next;
    logic [svpd_pkg::PERM_W-1:0] out_perm_reg, out_perm_next;
    logic [SIZE_BITS-1:0]    out_size_reg, out_size_next;
    logic                    out_last_reg, out_last_next;

    logic [PW-1:0]           prod;
    logic [PW-1:0]           psum_sum;
    logic                    mul_last;
    logic                    swap;
    logic                    j_last;
    logic                    k_last;
    logic                    do_clear;

    svpd_ram #(
        .WIDTH (REC_W),
        .DEPTH (MAX_DIMS)
    ) u_store (
        .clk     (clk),
        .wr_en   (we),
        .wr_addr (waddr),
        .wr_data (wdata),
        .rd_en   (re),
        .rd_addr (raddr),
        .rd_data (rdata)
    );

    assign rd_idx     = rdata[IDX_W-1:0];
    assign rd_size    = rdata[IDX_W +: SIZE_BITS];
    assign rd_stride  = rdata[IDX_W + SIZE_BITS +: STRIDE_BITS];
    assign piv_size   = pivot_reg[IDX_W +: SIZE_BITS];
    assign piv_stride = pivot_reg[IDX_W + SIZE_BITS +: STRIDE_BITS];

    // one operand slice per cycle; later slices weigh in through the shifted multiplicand
    assign prod     = mcand_reg * PW'(op_reg[svpd_pkg::CHUNK_W-1:0]);
    assign psum_sum = psum_reg + prod;
    assign mul_last = (op_reg >> svpd_pkg::CHUNK_W) == '0;

    assign swap   = (piv_stride < rd_stride) ||
                    ((piv_stride == rd_stride) && (piv_size < rd_size));
    assign j_last = CNT_W'(j_reg) == (view_count_reg - CNT_W'(1));
    assign k_last = CNT_W'(k_reg) == (view_count_reg - CNT_W'(1));

    always_comb
    begin
        status.in_need_mul   = !mode || size_present;
        status.in_last       = last;
        status.mul_last      = mul_last;
        status.pre_reject    = overflow_reg || (view_count_reg == '0) ||
                               (view_product_reg != base_product_reg);
        status.single        = view_count_reg == CNT_W'(1);
        status.j_last        = j_last;
        status.sort_more     = (CNT_W'(i_reg) + CNT_W'(2)) < view_count_reg;
        status.dense_bad     = running_reg != PW'(rd_stride);
        status.d_zero        = d_reg == '0;
        status.base_mismatch = base_size_count_reg != base_stride_count_reg;
        status.k_last        = k_last;
        status.out_free      = !out_valid_reg || result_ready;
    end

    always_comb
    begin
        view_count_next        = view_count_reg;
        base_size_count_next   = base_size_count_reg;
        base_stride_count_next = base_stride_count_reg;
        view_product_next      = view_product_reg;
        base_product_next      = base_product_reg;
        running_next           = running_reg;
        overflow_next          = overflow_reg;
        i_next                 = i_reg;
        j_next                 = j_reg;
        d_next                 = d_reg;
        k_next                 = k_reg;
        pivot_next             = pivot_reg;
        mcand_next             = mcand_reg;
        op_next                = op_reg;
        psum_next              = psum_reg;
        msel_next              = msel_reg;
        perm_next              = perm_reg;
        out_accepted_next      = out_accepted_reg;
        out_perm_next          = out_perm_reg;
        out_size_next          = out_size_reg;
        out_last_next          = out_last_reg;
        out_valid_next         = out_valid_reg && !result_ready;
        we                     = 1'b0;
        waddr                  = '0;
        wdata                  = pivot_reg;
        re                     = 1'b0;
        raddr                  = '0;
        do_clear               = 1'b0;

        unique case (cmd)
            svpd_pkg::CMD_NOP:
            begin
            end
            svpd_pkg::CMD_ACCEPT:
            begin
                if (!mode)
                begin
                    if (view_count_reg < CNT_W'(MAX_DIMS))
                    begin
                        we              = 1'b1;
                        waddr           = view_count_reg[IDX_W-1:0];
                        wdata           = {dim_stride, dim_size, view_count_reg[IDX_W-1:0]};
                        view_count_next = view_count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        overflow_next = 1'b1;
                    end
                    msel_next  = MT_VIEW;
                    mcand_next = view_product_reg;
                end
                else
                begin
                    if (size_present)
                    begin
                        base_size_count_next = base_size_count_reg + BW'(1);
                    end
                    if (stride_present)
                    begin
                        base_stride_count_next = base_stride_count_reg + BW'(1);
                    end
                    msel_next  = MT_BASE;
                    mcand_next = base_product_reg;
                end
                op_next   = OP_W'(dim_size);
                psum_next = '0;
            end
            svpd_pkg::CMD_MUL_STEP, svpd_pkg::CMD_DENSE_MUL:
            begin
                psum_next  = psum_sum;
                mcand_next = mcand_reg << svpd_pkg::CHUNK_W;
                op_next    = op_reg >> svpd_pkg::CHUNK_W;
                if (mul_last)
                begin
                    unique case (msel_reg)
                        MT_VIEW: view_product_next = psum_sum;
                        MT_BASE: base_product_next = psum_sum;
                        MT_RUN:  running_next      = psum_sum;
                        default: running_next      = psum_sum;
                    endcase
                    if (cmd == svpd_pkg::CMD_DENSE_MUL)
                    begin
                        d_next = d_reg - IDX_W'(1);
                        k_next = '0;
                    end
                end
            end
            svpd_pkg::CMD_EVAL_INIT:
            begin
                i_next       = '0;
                running_next = PW'(1);
                d_next       = IDX_W'(view_count_reg - CNT_W'(1));
            end
            svpd_pkg::CMD_RD_I:
            begin
                re    = 1'b1;
                raddr = i_reg;
            end
            svpd_pkg::CMD_LOAD_PIVOT:
            begin
                pivot_next = rdata;
                j_next     = i_reg + IDX_W'(1);
                re         = 1'b1;
                raddr      = i_reg + IDX_W'(1);
            end
            svpd_pkg::CMD_COMPARE:
            begin
                if (swap)
                begin
                    we         = 1'b1;
                    waddr      = j_reg;
                    wdata      = pivot_reg;
                    pivot_next = rdata;
                end
                j_next = j_reg + IDX_W'(1);
                re     = !j_last;
                raddr  = j_reg + IDX_W'(1);
            end
            svpd_pkg::CMD_WRITE_PIVOT:
            begin
                we     = 1'b1;
                waddr  = i_reg;
                wdata  = pivot_reg;
                i_next = i_reg + IDX_W'(1);
            end
            svpd_pkg::CMD_RD_DENSE:
            begin
                re    = 1'b1;
                raddr = d_reg;
            end
            svpd_pkg::CMD_DENSE_CHECK:
            begin
                perm_next[rd_idx] = d_reg;
                msel_next         = MT_RUN;
                mcand_next        = running_reg;
                op_next           = OP_W'(rd_size);
                psum_next         = '0;
            end
            svpd_pkg::CMD_RD_OUT:
            begin
                re    = 1'b1;
                raddr = k_reg;
            end
            svpd_pkg::CMD_EMIT:
            begin
                out_valid_next    = 1'b1;
                out_accepted_next = 1'b1;
                out_perm_next     = svpd_pkg::PERM_W'(perm_reg[k_reg]);
                out_size_next     = rd_size;
                out_last_next     = k_last;
                k_next            = k_reg + IDX_W'(1);
                do_clear          = k_last;
            end
            svpd_pkg::CMD_REJECT:
            begin
                out_valid_next    = 1'b1;
                out_accepted_next = 1'b0;
                out_perm_next     = '0;
                out_size_next     = '0;
                out_last_next     = 1'b1;
                do_clear          = 1'b1;
            end
            default:
            begin
            end
        endcase

        if (do_clear)
        begin
            view_count_next        = '0;
            base_size_count_next   = '0;
            base_stride_count_next = '0;
            view_product_next      = PW'(1);
            base_product_next      = PW'(1);
            running_next           = PW'(1);
            overflow_next          = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_count_reg        <= '0;
            base_size_count_reg   <= '0;
            base_stride_count_reg <= '0;
            view_product_reg      <= PW'(1);
            base_product_reg      <= PW'(1);
            running_reg           <= PW'(1);
            overflow_reg          <= 1'b0;
            i_reg                 <= '0;
            j_reg                 <= '0;
            d_reg                 <= '0;
            k_reg                 <= '0;
            out_valid_reg         <= 1'b0;
        end
        else
        begin
            view_count_reg        <= view_count_next;
            base_size_count_reg   <= base_size_count_next;
            base_stride_count_reg <= base_stride_count_next;
            view_product_reg      <= view_product_next;
            base_product_reg      <= base_product_next;
            running_reg           <= running_next;
            overflow_reg          <= overflow_next;
            i_reg                 <= i_next;
            j_reg                 <= j_next;
            d_reg                 <= d_next;
            k_reg                 <= k_next;
            out_valid_reg         <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pivot_reg        <= pivot_next;
        mcand_reg        <= mcand_next;
        op_reg           <= op_next;
        psum_reg         <= psum_next;
        msel_reg         <= msel_next;
        perm_reg         <= perm_next;
        out_accepted_reg <= out_accepted_next;
        out_perm_reg     <= out_perm_next;
        out_size_reg     <= out_size_next;
        out_last_reg     <= out_last_next;
    end

    assign result_valid = out_valid_reg;
    assign accepted     = out_accepted_reg;
    assign perm_entry   = out_perm_reg;
    assign sorted_size  = out_size_reg;
    assign last_out     = out_last_reg;

endmodule

[design/svpd_controller.sv]
// ----------------------------------------------------------------------------
// svpd_controller: sequencing state machine
// Loads items, then runs sort, density check and result emission.
// ----------------------------------------------------------------------------
module svpd_controller (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   desc_valid,
    output logic                   desc_ready,
    input  svpd_pkg::svpd_status_t status,
    output svpd_pkg::svpd_cmd_t    cmd
);

    typedef enum logic [12:0] {
        ST_IDLE      = 13'b0000000000001,
        ST_MUL       = 13'b0000000000010,
        ST_EVAL      = 13'b0000000000100,
        ST_SORT_LDI  = 13'b0000000001000,
        ST_SORT_LDJ  = 13'b0000000010000,
        ST_SORT_CMP  = 13'b0000000100000,
        ST_SORT_WRI  = 13'b0000001000000,
        ST_DENSE_RD  = 13'b0000010000000,
        ST_DENSE_CHK = 13'b0000100000000,
        ST_DENSE_MUL = 13'b0001000000000,
        ST_OUT_RD    = 13'b0010000000000,
        ST_OUT_EMIT  = 13'b0100000000000,
        ST_REJECT    = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;
    logic   last_reg, last_next;

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        cmd        = svpd_pkg::CMD_NOP;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (desc_valid)
                begin
                    cmd       = svpd_pkg::CMD_ACCEPT;
                    last_next = status.in_last;
                    if (status.in_need_mul)
                    begin
                        state_next = ST_MUL;
                    end
                    else if (status.in_last)
                    begin
                        state_next = ST_EVAL;
                    end
                end
            end
            ST_MUL:
            begin
                cmd = svpd_pkg::CMD_MUL_STEP;
                if (status.mul_last)
                begin
                    state_next = last_reg ? ST_EVAL : ST_IDLE;
                end
            end
            ST_EVAL:
            begin
                cmd = svpd_pkg::CMD_EVAL_INIT;
                if (status.pre_reject)
                begin
                    state_next = ST_REJECT;
                end
                else if (status.single)
                begin
                    state_next = ST_DENSE_RD;
                end
                else
                begin
                    state_next = ST_SORT_LDI;
                end
            end
            ST_SORT_LDI:
            begin
                cmd        = svpd_pkg::CMD_RD_I;
                state_next = ST_SORT_LDJ;
            end
            ST_SORT_LDJ:
            begin
                cmd        = svpd_pkg::CMD_LOAD_PIVOT;
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                cmd = svpd_pkg::CMD_COMPARE;
                if (status.j_last)
                begin
                    state_next = ST_SORT_WRI;
                end
            end
            ST_SORT_WRI:
            begin
                cmd        = svpd_pkg::CMD_WRITE_PIVOT;
                state_next = status.sort_more ? ST_SORT_LDI : ST_DENSE_RD;
            end
            ST_DENSE_RD:
            begin
                cmd        = svpd_pkg::CMD_RD_DENSE;
                state_next = ST_DENSE_CHK;
            end
            ST_DENSE_CHK:
            begin
                cmd        = svpd_pkg::CMD_DENSE_CHECK;
                state_next = status.dense_bad ? ST_REJECT : ST_DENSE_MUL;
            end
            ST_DENSE_MUL:
            begin
                cmd = svpd_pkg::CMD_DENSE_MUL;
                if (status.mul_last)
                begin
                    if (!status.d_zero)
                    begin
                        state_next = ST_DENSE_RD;
                    end
                    else
                    begin
                        state_next = status.base_mismatch ? ST_REJECT : ST_OUT_RD;
                    end
                end
            end
            ST_OUT_RD:
            begin
                cmd        = svpd_pkg::CMD_RD_OUT;
                state_next = ST_OUT_EMIT;
            end
            ST_OUT_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd        = svpd_pkg::CMD_EMIT;
                    state_next = status.k_last ? ST_IDLE : ST_OUT_RD;
                end
            end
            ST_REJECT:
            begin
                if (status.out_free)
                begin
                    cmd        = svpd_pkg::CMD_REJECT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    assign desc_ready = state_reg == ST_IDLE;

endmodule

[design/strided_view_permute_detect.sv]
// ----------------------------------------------------------------------------
// strided_view_permute_detect: strided view axis permutation detector
// Decides whether a strided view is a pure permutation of a dense base tensor.
// ----------------------------------------------------------------------------
// Usage:
//   desc   - descriptor items, one transaction each. mode 0 is a view dimension
//            (size, stride), mode 1 a base dimension (size, presence flags).
//            The transaction with last set closes the descriptor.
//   result - one transaction per view axis in sorted order (perm_entry,
//            sorted_size), last_out on the final one; or a single reject
//            transaction with accepted low.
// Items: an item that updates an element count is multiplied in 16-bit
//   slices of its size, up to the top nonzero slice, on the single shared
//   64 x 16 multiplier, and no new item is taken until it is done; a base
//   item without a size needs no multiply.
// Evaluation after the last item, rank n: pre-checks, then for each sort row
//   i a read, a pivot load, n-1-i compares and a write-back (one descriptor
//   RAM port pair), then n density steps, each a read, a check and the
//   multiply slices, then a read and an emit per result. Reject paths end early.
// The result register parts the two sides: the next descriptor may load while
//   the final result still waits; a stalled receiver holds the controller in
//   its emit or reject state. Reset clears counters, products and the result
//   valid; the descriptor RAM needs no clearing.
// ----------------------------------------------------------------------------
module strided_view_permute_detect #(
    parameter int MAX_DIMS    = 8,
    parameter int SIZE_BITS   = 32,
    parameter int STRIDE_BITS = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    svpd_in_if.sink     desc,
    svpd_out_if.source  result
);

    svpd_pkg::svpd_cmd_t    cmd;
    svpd_pkg::svpd_status_t status;

    // Control: item loading and the evaluation sequence.
    svpd_controller u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .desc_valid (desc.valid),
        .desc_ready (desc.ready),
        .status     (status),
        .cmd        (cmd)
    );

    // Datapath: descriptor RAM, counters, product unit and result register.
    svpd_datapath #(
        .MAX_DIMS    (MAX_DIMS),
        .SIZE_BITS   (SIZE_BITS),
        .STRIDE_BITS (STRIDE_BITS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .mode           (desc.mode),
        .dim_size       (desc.dim_size),
        .dim_stride     (desc.dim_stride),
        .size_present   (desc.size_present),
        .stride_present (desc.stride_present),
        .last           (desc.last),
        .result_ready   (result.ready),
        .result_valid   (result.valid),
        .accepted       (result.accepted),
        .perm_entry     (result.perm_entry),
        .sorted_size    (result.sorted_size),
        .last_out       (result.last_out)
    );

endmodule

[design/svpd_checker.sv]
// ----------------------------------------------------------------------------
// svpd_checker: port-level checks for the permute detector
// Bound to the top level; sees only its ports.
// ----------------------------------------------------------------------------
module svpd_checker #(
    parameter int SIZE_BITS = 32
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 in_mode,
    input logic                 in_size_present,
    input logic                 in_last,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic                 out_accepted,
    input logic [2:0]           out_perm,
    input logic [SIZE_BITS-1:0] out_size,
    input logic                 out_last
);

    // stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_accepted) &&
        $stable(out_perm) && $stable(out_size) && $stable(out_last))
        else $error("result changed while stalled");

    // a reject is a single closing transaction with zero payload
    a_reject_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_accepted |-> out_last && (out_perm == '0) && (out_size == '0))
        else $error("malformed reject result");

    // closing item starts evaluation: no item taken in the next cycle
    a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_last |=> !in_ready)
        else $error("item accepted right after descriptor end");

    // base item without a size needs no multiply: ready again next cycle
    a_base_fast: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !in_last && in_mode && !in_size_present |=> in_ready)
        else $error("sizeless base item stalled the channel");

endmodule

bind strided_view_permute_detect svpd_checker #(
    .SIZE_BITS (SIZE_BITS)
) u_svpd_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (desc.valid),
    .in_ready        (desc.ready),
    .in_mode         (desc.mode),
    .in_size_present (desc.size_present),
    .in_last         (desc.last),
    .out_valid       (result.valid),
    .out_ready       (result.ready),
    .out_accepted    (result.accepted),
    .out_perm        (result.perm_entry),
    .out_size        (result.sorted_size),
    .out_last        (result.last_out)
);

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: strided view permute detector
// A stimulus table of descriptors runs first: rank zero, a full-width size,
// zero size, transpose, a stride gap, short base lists, absent base sizes,
// equal strides and too many axes. Random descriptors follow, most of them
// dense permutations with random content and the rest broken or noise. Every
// result transaction is checked against an in-bench predictor, with a few
// table rows carrying their result typed in. Both sides idle at random, and
// the receiver once holds off long enough to back the block up.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_DIMS     = 8;
    localparam int SIZE_BITS    = 32;
    localparam int STRIDE_BITS  = 48;
    localparam int RANDOM_ITEMS = 250;
    // Drain with margin once nothing is owed.
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 400;
    localparam int CYCLE_LIMIT  = 400000;

    // Item kinds on the descriptor channel
    localparam logic MODE_VIEW = 1'b0;
    localparam logic MODE_BASE = 1'b1;

    // How a table row's result is known: from the predictor, or typed in
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_REJECT,
        CHK_SINGLE
    } chk_kind_t;

    typedef struct packed {
        logic                   mode;
        logic [SIZE_BITS-1:0]   size;
        logic [STRIDE_BITS-1:0] stride;
        logic                   size_present;
        logic                   stride_present;
        logic                   last;
        chk_kind_t              chk;
        logic [SIZE_BITS-1:0]   chk_size;
    } dim_item_t;

    typedef struct packed {
        logic                          accepted;
        logic [svpd_pkg::PERM_W-1:0]   perm_entry;
        logic [SIZE_BITS-1:0]          sorted_size;
        logic                          last_out;
    } perm_result_t;

    localparam perm_result_t REJECT_RESULT = '{1'b0, 3'd0, 32'd0, 1'b1};

    // Directed descriptors. Only the row carrying last has a check kind
    // that matters; the result is typed in where it is obvious.
    localparam int N_DIRECTED = 26;
    localparam dim_item_t DIRECTED_ROWS [N_DIRECTED] = '{
        // rank zero: base items only
        '{MODE_BASE, 32'd5,           48'd0,             1'b1, 1'b1, 1'b1, CHK_REJECT, 32'd0},
        // single axis with the largest size; base stride field is ignored
        '{MODE_VIEW, 32'hFFFF_FFFF,   48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_BASE, 32'hFFFF_FFFF,   48'hFFFF_FFFF_FFFF, 1'b1, 1'b1, 1'b1, CHK_SINGLE,
          32'hFFFF_FFFF},
        // zero size axis: element counts 0 vs 1
        '{MODE_VIEW, 32'd0,           48'd1,             1'b0, 1'b0, 1'b1, CHK_REJECT, 32'd0},
        // 2D transpose of a 4x3 base
        '{MODE_VIEW, 32'd3,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd4,           48'd3,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_BASE, 32'd4,           48'd0,             1'b1, 1'b1, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_BASE, 32'd3,           48'd0,             1'b1, 1'b1, 1'b1, CHK_MODEL,  32'd0},
        // innermost stride is not 1
        '{MODE_VIEW, 32'd5,           48'd2,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_BASE, 32'd5,           48'd0,             1'b1, 1'b1, 1'b1, CHK_REJECT, 32'd0},
        // base stride list one shorter than the size list
        '{MODE_VIEW, 32'd7,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_BASE, 32'd7,           48'd0,             1'b1, 1'b0, 1'b1, CHK_REJECT, 32'd0},
        // base size absent leaves the base count at one
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_BASE, 32'hDEAD_BEEF,   48'd0,             1'b0, 1'b0, 1'b1, CHK_SINGLE, 32'd1},
        // equal strides, tie broken by descending size
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd2,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_BASE, 32'd2,           48'd1,             1'b1, 1'b1, 1'b1, CHK_MODEL,  32'd0},
        // one view axis more than the block holds
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b0, CHK_MODEL,  32'd0},
        '{MODE_VIEW, 32'd1,           48'd1,             1'b0, 1'b0, 1'b1, CHK_REJECT, 32'd0}
    };

    logic clk;
    logic rst_n;

    svpd_in_if  #(.SIZE_BITS(SIZE_BITS), .STRIDE_BITS(STRIDE_BITS)) desc_if ();
    svpd_out_if #(.SIZE_BITS(SIZE_BITS))                            res_if ();

    strided_view_permute_detect #(
        .MAX_DIMS    (MAX_DIMS),
        .SIZE_BITS   (SIZE_BITS),
        .STRIDE_BITS (STRIDE_BITS)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .desc   (desc_if),
        .result (res_if)
    );

    // ------------------------------------------------------------------------
    // Predictor state: one descriptor being collected
    // ------------------------------------------------------------------------
    logic [SIZE_BITS-1:0]            held_size   [MAX_DIMS];
    logic [STRIDE_BITS-1:0]          held_stride [MAX_DIMS];
    logic [svpd_pkg::PERM_W-1:0]     held_axis   [MAX_DIMS];
    logic [3:0]                      view_axes         = '0;
    logic [svpd_pkg::BASE_CNT_W-1:0] base_size_tally   = '0;
    logic [svpd_pkg::BASE_CNT_W-1:0] base_stride_tally = '0;
    logic [svpd_pkg::PROD_W-1:0]     view_elems        = 64'd1;
    logic [svpd_pkg::PROD_W-1:0]     base_elems        = 64'd1;
    logic                            too_many_axes     = 1'b0;

    dim_item_t    pending_items [$];   // items not yet offered
    perm_result_t expected_perm [$];   // results still owed by the block

    int items_queued   = 0;
    int items_taken    = 0;
    int results_seen   = 0;
    int desc_accepted  = 0;
    int desc_rejected  = 0;
    int errors         = 0;
    int cycles         = 0;

    logic pressure_go   = 1'b0;
    logic pressure_done = 1'b0;

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    // Take one accepted item into the predictor. On the closing item the
    // descriptor is evaluated and its results join the expectation queue.
    task automatic absorb_dim_item(input dim_item_t it);
        perm_result_t                outs [$];
        perm_result_t                r;
        logic [svpd_pkg::PROD_W-1:0] run;
        logic [svpd_pkg::PERM_W-1:0] inv [MAX_DIMS];
        logic [SIZE_BITS-1:0]        ts;
        logic [STRIDE_BITS-1:0]      tst;
        logic [svpd_pkg::PERM_W-1:0] tx;
        logic [svpd_pkg::PERM_W-1:0] slot;
        logic                        dense;
        int                          n;
        slot = view_axes[svpd_pkg::PERM_W-1:0];
        if (it.mode == MODE_VIEW)
        begin
            view_elems = view_elems * {32'd0, it.size};
            if (view_axes < 4'(MAX_DIMS))
            begin
                held_size[slot]   = it.size;
                held_stride[slot] = it.stride;
                held_axis[slot]   = slot;
                view_axes         = view_axes + 4'd1;
            end
            else
            begin
                too_many_axes = 1'b1;
            end
        end
        else
        begin
            if (it.size_present)
            begin
                base_elems      = base_elems * {32'd0, it.size};
                base_size_tally = base_size_tally + 1'b1;
            end
            if (it.stride_present)
                base_stride_tally = base_stride_tally + 1'b1;
        end
        if (!it.last)
            return;

        n = int'(view_axes);
        if (too_many_axes || n == 0 || view_elems != base_elems)
        begin
            outs.push_back(REJECT_RESULT);
        end
        else
        begin
            // exchange sort: descending stride, then descending size
            for (int i = 0; i + 1 < n; i++)
            begin
                for (int j = i + 1; j < n; j++)
                begin
                    if (held_stride[i] < held_stride[j] ||
                        (held_stride[i] == held_stride[j] && held_size[i] < held_size[j]))
                    begin
                        ts  = held_size[i];   held_size[i]   = held_size[j];   held_size[j]   = ts;
                        tst = held_stride[i]; held_stride[i] = held_stride[j]; held_stride[j] = tst;
                        tx  = held_axis[i];   held_axis[i]   = held_axis[j];   held_axis[j]   = tx;
                    end
                end
            end
            // density, innermost axis first, 64-bit running stride
            dense = 1'b1;
            run   = 64'd1;
            for (int i = n - 1; i >= 0 && dense; i--)
            begin
                if (run != {16'd0, held_stride[i]})
                    dense = 1'b0;
                run = run * {32'd0, held_size[i]};
            end
            if (!dense || base_size_tally != base_stride_tally)
            begin
                outs.push_back(REJECT_RESULT);
            end
            else
            begin
                for (int i = 0; i < MAX_DIMS; i++)
                    inv[i] = '0;
                for (int i = 0; i < n; i++)
                    inv[held_axis[i]] = i[svpd_pkg::PERM_W-1:0];
                for (int i = 0; i < n; i++)
                begin
                    r = '{1'b1, inv[i], held_size[i], (i == n - 1)};
                    outs.push_back(r);
                end
            end
        end

        // rows with a typed-in result replace the prediction
        if (it.chk == CHK_REJECT)
        begin
            outs.delete();
            outs.push_back(REJECT_RESULT);
        end
        else if (it.chk == CHK_SINGLE)
        begin
            outs.delete();
            r = '{1'b1, 3'd0, it.chk_size, 1'b1};
            outs.push_back(r);
        end

        if (outs[0].accepted)
            desc_accepted++;
        else
            desc_rejected++;
        foreach (outs[i])
            expected_perm.push_back(outs[i]);

        view_axes         = '0;
        base_size_tally   = '0;
        base_stride_tally = '0;
        view_elems        = 64'd1;
        base_elems        = 64'd1;
        too_many_axes     = 1'b0;
    endtask

    function automatic logic [SIZE_BITS-1:0] pick_axis_size();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return 32'd1;
        else if (r < 3)
            return $urandom_range(1, 65535);
        else if (r == 3)
            return $urandom;
        else
            return $urandom_range(2, 6);
    endfunction

    // Build one random descriptor and append it to the send queue.
    // Mostly dense permutations (some with one defect), then too many axes,
    // rank zero and plain noise.
    task automatic queue_random_descriptor();
        dim_item_t                   views  [$];
        dim_item_t                   bases  [$];
        dim_item_t                   merged [$];
        dim_item_t                   it;
        logic [SIZE_BITS-1:0]        psize   [MAX_DIMS];
        logic [svpd_pkg::PROD_W-1:0] pstride [MAX_DIMS];
        int                          order [MAX_DIMS];
        int                          n, kind, tmp, j, k;
        kind = $urandom_range(0, 99);
        if (kind < 75)
        begin
            n = $urandom_range(1, MAX_DIMS);
            for (int p = 0; p < n; p++)
            begin
                psize[p]   = pick_axis_size();
                pstride[p] = (p == 0) ? 64'd1 : pstride[p-1] * {32'd0, psize[p-1]};
                order[p]   = p;
            end
            for (int i = n - 1; i > 0; i--)
            begin
                j = $urandom_range(0, i);
                tmp = order[i]; order[i] = order[j]; order[j] = tmp;
            end
            for (int v = 0; v < n; v++)
            begin
                it        = '0;
                it.mode   = MODE_VIEW;
                it.size   = psize[order[v]];
                it.stride = pstride[order[v]][STRIDE_BITS-1:0];
                views.push_back(it);
            end
            for (int p = 0; p < n; p++)
            begin
                it                = '0;
                it.mode           = MODE_BASE;
                it.size           = psize[p];
                it.stride         = STRIDE_BITS'({$urandom, $urandom});
                it.size_present   = 1'b1;
                it.stride_present = 1'b1;
                bases.push_back(it);
            end
            // neutral base entries: absent from both lists, or size one
            repeat ($urandom_range(0, 2))
            begin
                it                = '0;
                it.mode           = MODE_BASE;
                it.size_present   = 1'($urandom_range(0, 1));
                it.stride_present = it.size_present;
                it.size           = it.size_present ? 32'd1 : $urandom;
                bases.push_back(it);
            end
            if (kind >= 60)
            begin
                case ($urandom_range(0, 4))
                    0:
                    begin
                        k = $urandom_range(0, views.size() - 1);
                        views[k].stride ^= 48'd1 << $urandom_range(0, STRIDE_BITS - 1);
                    end
                    1:
                    begin
                        k = $urandom_range(0, n - 1);
                        bases[k].size = bases[k].size + 32'd1;
                    end
                    2:
                    begin
                        k = $urandom_range(0, n - 1);
                        bases[k].stride_present = 1'b0;
                    end
                    3:
                    begin
                        it        = '0;
                        it.mode   = MODE_VIEW;
                        it.size   = 32'd1;
                        it.stride = STRIDE_BITS'($urandom_range(0, 3));
                        views.push_back(it);
                    end
                    default:
                    begin
                        k = $urandom_range(0, views.size() - 1);
                        views[k].size = '0;
                    end
                endcase
            end
        end
        else if (kind < 85)
        begin
            repeat ($urandom_range(MAX_DIMS + 1, MAX_DIMS + 3))
            begin
                it        = '0;
                it.mode   = MODE_VIEW;
                it.size   = $urandom_range(1, 4);
                it.stride = STRIDE_BITS'($urandom_range(0, 64));
                views.push_back(it);
            end
            it              = '0;
            it.mode         = MODE_BASE;
            it.size         = $urandom_range(1, 4);
            it.size_present = 1'b1;
            bases.push_back(it);
        end
        else if (kind < 90)
        begin
            // rank zero; up to 17 entries so the 4-bit list counters wrap
            repeat ($urandom_range(1, 17))
            begin
                it                = '0;
                it.mode           = MODE_BASE;
                it.size           = $urandom_range(0, 3);
                it.size_present   = 1'($urandom_range(0, 1));
                it.stride_present = 1'($urandom_range(0, 1));
                bases.push_back(it);
            end
        end
        else
        begin
            repeat ($urandom_range(1, 10))
            begin
                it                = '0;
                it.mode           = 1'($urandom_range(0, 1));
                it.size           = $urandom;
                it.stride         = STRIDE_BITS'({$urandom, $urandom});
                it.size_present   = 1'($urandom_range(0, 1));
                it.stride_present = 1'($urandom_range(0, 1));
                views.push_back(it);
            end
        end
        // interleave, keeping the view axis order
        while (views.size() != 0 || bases.size() != 0)
        begin
            if (views.size() != 0 && (bases.size() == 0 || $urandom_range(0, 1) == 1))
                merged.push_back(views.pop_front());
            else
                merged.push_back(bases.pop_front());
        end
        merged[merged.size() - 1].last = 1'b1;
        foreach (merged[i])
            pending_items.push_back(merged[i]);
        items_queued += merged.size();
    endtask

    // ------------------------------------------------------------------------
    // Clock, reset, cycle limit
    // ------------------------------------------------------------------------
    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        rst_n <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles, %0d results still owed", cycles,
                     expected_perm.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Descriptor sender: bursts of random length with random gaps. An item
    // that was offered stays on the bus until the block takes it; the
    // predictor sees each item at the edge where the transaction completes.
    // ------------------------------------------------------------------------
    dim_item_t on_bus;
    int        burst_left = 1;
    int        gap_left   = 0;

    initial
    begin
        desc_if.valid          <= 1'b0;
        desc_if.mode           <= MODE_VIEW;
        desc_if.dim_size       <= '0;
        desc_if.dim_stride     <= '0;
        desc_if.size_present   <= 1'b0;
        desc_if.stride_present <= 1'b0;
        desc_if.last           <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (desc_if.valid && desc_if.ready)
            begin
                absorb_dim_item(on_bus);
                items_taken++;
            end
            // an unaccepted item holds; otherwise pick the next bus state
            if (!(desc_if.valid && !desc_if.ready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    desc_if.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    on_bus = pending_items.pop_front();
                    desc_if.valid          <= 1'b1;
                    desc_if.mode           <= on_bus.mode;
                    desc_if.dim_size       <= on_bus.size;
                    desc_if.dim_stride     <= on_bus.stride;
                    desc_if.size_present   <= on_bus.size_present;
                    desc_if.stride_present <= on_bus.stride_present;
                    desc_if.last           <= on_bus.last;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 12);
                        // a quarter of the bursts run straight on
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                begin
                    desc_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: alternates quiet stretches with short random stalls.
    // Once the random phase starts it holds ready low for HOLD_CYCLES so the
    // result register and then the descriptor input back up.
    // ------------------------------------------------------------------------
    int   rx_cycle   = 0;
    int   stall_left = 0;
    int   hold_count = 0;
    logic rx_ready;

    initial
    begin
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            rx_cycle++;
            if (pressure_go && !pressure_done)
            begin
                hold_count++;
                rx_ready = 1'b0;
                if (hold_count >= HOLD_CYCLES)
                    pressure_done = 1'b1;
            end
            else if (rx_cycle[7])
            begin
                rx_ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                rx_ready = 1'b0;
            end
            else
            begin
                rx_ready = 1'b1;
                if ($urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 12);
            end
            res_if.ready <= rx_ready;
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every completed transaction against the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------------
    perm_result_t want;

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            results_seen++;
            if (expected_perm.size() == 0)
            begin
                report_mismatch($sformatf("result with nothing owed: acc=%0b perm=%0d size=%0h",
                                          res_if.accepted, res_if.perm_entry,
                                          res_if.sorted_size));
            end
            else
            begin
                want = expected_perm.pop_front();
                if (res_if.accepted !== want.accepted)
                    report_mismatch($sformatf("accepted %0b, want %0b",
                                              res_if.accepted, want.accepted));
                if (res_if.perm_entry !== want.perm_entry)
                    report_mismatch($sformatf("perm_entry %0d, want %0d",
                                              res_if.perm_entry, want.perm_entry));
                if (res_if.sorted_size !== want.sorted_size)
                    report_mismatch($sformatf("sorted_size %0h, want %0h",
                                              res_if.sorted_size, want.sorted_size));
                if (res_if.last_out !== want.last_out)
                    report_mismatch($sformatf("last_out %0b, want %0b",
                                              res_if.last_out, want.last_out));
            end
        end
    end

    // ------------------------------------------------------------------------
    // Sequence: table, then random descriptors, then drain and verdict
    // ------------------------------------------------------------------------
    initial
    begin
        wait (rst_n === 1'b1);

        foreach (DIRECTED_ROWS[i])
            pending_items.push_back(DIRECTED_ROWS[i]);
        items_queued = N_DIRECTED;
        while (items_taken < items_queued || expected_perm.size() != 0)
            @(posedge clk);

        while (items_queued - N_DIRECTED < RANDOM_ITEMS)
            queue_random_descriptor();
        pressure_go = 1'b1;

        while (items_taken < items_queued || expected_perm.size() != 0)
            @(posedge clk);
        // the block may still be finishing; anything late is unexpected
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_perm.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_perm.size()));

        $display("Ran %0d items in %0d descriptors (%0d accepted, %0d rejected), %0d results",
                 items_taken, desc_accepted + desc_rejected, desc_accepted, desc_rejected,
                 results_seen);
        $display("Receiver held off %0d cycles with the sender still offering; %0d errors",
                 hold_count, errors);
        if (errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[strided_view_permute_detect.f]
design/svpd_pkg.sv
design/svpd_in_if.sv
design/svpd_out_if.sv
design/svpd_ram.sv
design/svpd_datapath.sv
design/svpd_controller.sv
design/strided_view_permute_detect.sv
design/svpd_checker.sv
sim/testbench.sv
